// ===== src/cpa_pkg.sv =====
// Shared types and constants for the contiguous page allocator.
// No dependencies; imported by every module of the block.
package cpa_pkg;

    localparam int MAX_PAGES  = 32768;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 56;
    localparam int CNT_W      = 16;
    localparam int IDX_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    // page counter: holds any index and the page count itself
    localparam int PCW        = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

    typedef enum logic [1:0] {
        ST_DONE         = 2'd0,
        ST_BAD_COUNT    = 2'd1,
        ST_NO_ROOM      = 2'd2,
        ST_FREE_IGNORED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_NUM_PAGES      = 2'd0,
        CFG_RESERVED_PAGES = 2'd1,
        CFG_MEMORY_BASE    = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REJECT = 2'd2
    } op_t;

    // Classified request handed from front to back
    typedef struct packed {
        op_t              op;
        status_t          status;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] idx;
    } req_t;

    // Live configuration seen by the back end
    typedef struct packed {
        logic [PCW-1:0]    live_n;
        logic [PCW-1:0]    reserved;
        logic [ADDR_W-1:0] base;
    } cfg_t;

endpackage

// ===== src/cpa_front.sv =====
// Front end: configuration registers, request classification and request queue.
// Depends on cpa_pkg.
module cpa_front
    import cpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [ADDR_W-1:0] cfg_data,
    input  logic              push,
    input  logic              block_in,
    output logic              full,
    input  logic              req_type,
    input  logic [CNT_W-1:0]  page_count,
    input  logic [ADDR_W-1:0] free_address,
    output cfg_t              cfg,
    output logic              req_valid,
    output req_t              req,
    input  logic              req_take
);

    logic [CNT_W-1:0]  num_pages_reg;
    logic [CNT_W-1:0]  reserved_reg;
    logic [ADDR_W-1:0] base_reg;

    req_t       q_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    req_t              cls;
    logic [ADDR_W-1:0] diff;
    logic [ADDR_W-1:0] idx_full;
    logic              do_push;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_pages_reg <= CNT_W'(32768);
            reserved_reg  <= '0;
            base_reg      <= ADDR_W'(64'h8000_0000);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_NUM_PAGES:      num_pages_reg <= cfg_data[CNT_W-1:0];
                CFG_RESERVED_PAGES: reserved_reg  <= cfg_data[CNT_W-1:0];
                CFG_MEMORY_BASE:    base_reg      <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        cfg.live_n   = (PCW'(num_pages_reg) > PCW'(MAX_PAGES)) ? PCW'(MAX_PAGES)
                                                               : PCW'(num_pages_reg);
        cfg.reserved = PCW'(reserved_reg);
        cfg.base     = base_reg;
    end

    // Classify the incoming transaction
    always_comb
    begin
        diff     = free_address - base_reg;
        idx_full = diff >> PAGE_SHIFT;
        cls.count  = page_count;
        cls.idx    = idx_full[IDX_W-1:0];
        cls.op     = OP_REJECT;
        cls.status = ST_DONE;
        if (!req_type)
        begin
            if (page_count == '0 || PCW'(page_count) > cfg.live_n)
                cls.status = ST_BAD_COUNT;
            else
                cls.op = OP_ALLOC;
        end
        else
        begin
            if (free_address == '0 || free_address < base_reg)
                cls.status = ST_FREE_IGNORED;
            else if (idx_full >= ADDR_W'(cfg.live_n) || idx_full < ADDR_W'(cfg.reserved))
                cls.status = ST_FREE_IGNORED;
            else
                cls.op = OP_FREE;
        end
    end

    // Two-entry request queue
    assign full      = (cnt_reg == 2'd2) || block_in;
    assign do_push   = push && !full;
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wp_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wp_reg <= !wp_reg;
            if (req_take)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(req_take);
        end
    end

endmodule

// ===== src/cpa_back.sv =====
// Back end: page flag memory, clearing pass, first-fit scan, mark and free walk.
// Depends on cpa_pkg.
module cpa_back
    import cpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              req_valid,
    input  req_t              req,
    output logic              req_take,
    output logic              clearing,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] block_address
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_MARK, S_FREE_RD, S_FREE_EV
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  clr_reg;
    logic [PCW-1:0]    p_reg;
    logic [CNT_W-1:0]  run_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  start_reg;
    logic [IDX_W-1:0]  end_reg;
    logic [IDX_W-1:0]  k_reg;
    logic              first_reg;
    logic              res_valid_reg;
    status_t           res_status_reg;
    logic [ADDR_W-1:0] res_addr_reg;

    logic [1:0]        flags_mem [MAX_PAGES];
    logic [1:0]        rd_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [1:0]        mem_wd;
    logic [IDX_W-1:0]  mem_ra;

    logic              busy;
    logic [CNT_W-1:0]  run_inc;
    logic [PCW-1:0]    p_inc;

    assign req_take      = (state_reg == S_IDLE) && req_valid && !res_valid_reg;
    assign clearing      = (state_reg == S_CLEAR);
    assign empty         = !res_valid_reg;
    assign status        = res_status_reg;
    assign block_address = res_addr_reg;

    assign busy    = (p_reg < cfg.reserved) || rd_reg[0];
    assign run_inc = busy ? '0 : run_reg + CNT_W'(1);
    assign p_inc   = p_reg + PCW'(1);

    // Memory port decode
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_ra = p_reg[IDX_W-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
            end
            S_MARK:
            begin
                mem_we = 1'b1;
                mem_wa = k_reg;
                mem_wd = {k_reg == end_reg, 1'b1};
            end
            S_FREE_EV:
            begin
                mem_we = rd_reg[0];
                mem_wa = p_reg[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    // Page flag store, bit 0 taken, bit 1 last
    always_ff @(posedge clk)
    begin
        if (mem_we)
            flags_mem[mem_wa] <= mem_wd;
        rd_reg <= flags_mem[mem_ra];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            res_valid_reg  <= 1'b0;
            p_reg          <= '0;
            run_reg        <= '0;
            count_reg      <= '0;
            start_reg      <= '0;
            end_reg        <= '0;
            k_reg          <= '0;
            first_reg      <= 1'b0;
            res_status_reg <= ST_DONE;
            res_addr_reg   <= '0;
        end
        else
        begin
            if (pop && res_valid_reg)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + IDX_W'(1);
                    if (clr_reg == IDX_W'(MAX_PAGES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (req_take)
                    begin
                        count_reg <= req.count;
                        run_reg   <= '0;
                        first_reg <= 1'b1;
                        case (req.op)
                            OP_ALLOC:
                            begin
                                p_reg     <= '0;
                                state_reg <= S_SCAN_RD;
                            end
                            OP_FREE:
                            begin
                                p_reg     <= PCW'(req.idx);
                                state_reg <= S_FREE_RD;
                            end
                            default:
                            begin
                                res_valid_reg  <= 1'b1;
                                res_status_reg <= req.status;
                                res_addr_reg   <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN_RD:
                begin
                    if (p_reg >= cfg.live_n)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_status_reg <= ST_NO_ROOM;
                        res_addr_reg   <= '0;
                        state_reg      <= S_IDLE;
                    end
                    else
                        state_reg <= S_SCAN_EV;
                end
                S_SCAN_EV:
                begin
                    run_reg <= run_inc;
                    if (run_inc == count_reg)
                    begin
                        start_reg <= IDX_W'(p_inc - PCW'(count_reg));
                        k_reg     <= IDX_W'(p_inc - PCW'(count_reg));
                        end_reg   <= p_reg[IDX_W-1:0];
                        state_reg <= S_MARK;
                    end
                    else
                    begin
                        p_reg     <= p_inc;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_MARK:
                begin
                    k_reg <= k_reg + IDX_W'(1);
                    if (k_reg == end_reg)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_status_reg <= ST_DONE;
                        res_addr_reg   <= cfg.base + (ADDR_W'(start_reg) << PAGE_SHIFT);
                        state_reg      <= S_IDLE;
                    end
                end
                S_FREE_RD:
                begin
                    state_reg <= S_FREE_EV;
                end
                S_FREE_EV:
                begin
                    first_reg <= 1'b0;
                    if (!rd_reg[0])
                    begin
                        // start page free: ignored; later free page ends the walk
                        res_valid_reg  <= 1'b1;
                        res_status_reg <= first_reg ? ST_FREE_IGNORED : ST_DONE;
                        res_addr_reg   <= '0;
                        state_reg      <= S_IDLE;
                    end
                    else if (rd_reg[1] || p_inc >= cfg.live_n)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_status_reg <= ST_DONE;
                        res_addr_reg   <= '0;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        p_reg     <= p_inc;
                        state_reg <= S_FREE_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/contiguous_page_allocator.sv =====
// Contiguous page allocator, first fit. From acceptance to result: allocate reads and checks
// each page up to the end of the fitting run, then marks each page of the run; no room reads
// and checks every page in range; free reads and checks each page visited; rejected requests
// are answered from the idle state. One request at a time: a new one is taken only when idle
// with no result held; the flag read is registered, so each page costs a read and a check step.
// Reset: asynchronous, active low; a clearing pass over all MAX_PAGES pages follows, full high.
module contiguous_page_allocator
    import cpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [ADDR_W-1:0] cfg_data,
    input  logic              push,
    output logic              full,
    input  logic              req_type,
    input  logic [CNT_W-1:0]  page_count,
    input  logic [ADDR_W-1:0] free_address,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] block_address
);

    cfg_t cfg;
    req_t req;
    logic req_valid;
    logic req_take;
    logic clearing;

    cpa_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .block_in     (clearing),
        .full         (full),
        .req_type     (req_type),
        .page_count   (page_count),
        .free_address (free_address),
        .cfg          (cfg),
        .req_valid    (req_valid),
        .req          (req),
        .req_take     (req_take)
    );

    cpa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .req_valid     (req_valid),
        .req           (req),
        .req_take      (req_take),
        .clearing      (clearing),
        .empty         (empty),
        .pop           (pop),
        .status        (status),
        .block_address (block_address)
    );

endmodule

// ===== tb/contiguous_page_allocator_tb.sv =====
// Self-checking testbench for the first-fit contiguous page allocator.
// Depends on cpa_pkg and contiguous_page_allocator; drives a directed table,
// then random phases over several register settings, checked against table values or a predictor.
`timescale 1ns / 100ps

module contiguous_page_allocator_tb;
    import cpa_pkg::*;

    localparam logic [ADDR_W-1:0] RESET_BASE = 56'h80000000;

    typedef struct {
        logic              rt;
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] fa;
        bit                known;
        status_t           st;
        logic [ADDR_W-1:0] ba;
    } table_row_t;

    typedef struct {
        status_t           st;
        logic [ADDR_W-1:0] ba;
    } alloc_result_t;

    typedef struct {
        logic [CNT_W-1:0]  n;
        logic [CNT_W-1:0]  res;
        logic [ADDR_W-1:0] base;
        int                items;
        bit                big;
    } setting_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [ADDR_W-1:0] cfg_data;
    logic              push;
    logic              full;
    logic              req_type;
    logic [CNT_W-1:0]  page_count;
    logic [ADDR_W-1:0] free_address;
    logic              empty;
    logic              pop;
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_address;

    // predictor state
    logic [1:0]        pg_flags [MAX_PAGES];
    logic [CNT_W-1:0]  pg_num;
    logic [CNT_W-1:0]  pg_reserved;
    logic [ADDR_W-1:0] pg_base;

    alloc_result_t     pending_q[$];
    logic [ADDR_W-1:0] live_blocks[$];
    int                errors;
    int                sent;
    int                received;

    table_row_t        dir_rows[17];
    setting_t          settings[7];

    contiguous_page_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .req_type      (req_type),
        .page_count    (page_count),
        .free_address  (free_address),
        .empty         (empty),
        .pop           (pop),
        .status        (status),
        .block_address (block_address)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #30ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int live_count();
        return (pg_num > MAX_PAGES) ? MAX_PAGES : int'(pg_num);
    endfunction

    function automatic bit page_busy(input int p);
        if (p < int'(pg_reserved))
            return 1'b1;
        return pg_flags[p][0];
    endfunction

    // Model of one request; updates the page flags.
    function automatic alloc_result_t predict_request(input logic rt, input logic [CNT_W-1:0] cnt,
                                                      input logic [ADDR_W-1:0] fa);
        alloc_result_t     r;
        int                n;
        int                run;
        int                start;
        int                p;
        bit                found;
        bit                last;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] idx;
        logic [ADDR_W-1:0] sh;
        n       = live_count();
        r.st    = ST_DONE;
        r.ba    = '0;
        found   = 1'b0;
        run     = 0;
        start   = 0;
        if (rt == 1'b0)
        begin
            if (cnt == 0 || int'(cnt) > n)
                r.st = ST_BAD_COUNT;
            else
            begin
                for (p = 0; p < n && !found; p++)
                begin
                    run = page_busy(p) ? 0 : run + 1;
                    if (run == int'(cnt))
                    begin
                        start = p + 1 - int'(cnt);
                        found = 1'b1;
                    end
                end
                if (!found)
                    r.st = ST_NO_ROOM;
                else
                begin
                    for (p = start; p < start + int'(cnt); p++)
                        pg_flags[p][0] = 1'b1;
                    pg_flags[start + int'(cnt) - 1][1] = 1'b1;
                    sh   = ADDR_W'(start);
                    r.ba = pg_base + (sh << PAGE_SHIFT);
                end
            end
        end
        else
        begin
            if (fa == 0 || fa < pg_base)
                r.st = ST_FREE_IGNORED;
            else
            begin
                off = fa - pg_base;
                idx = off >> PAGE_SHIFT;
                if (idx >= ADDR_W'(n) || idx < ADDR_W'(pg_reserved) || !page_busy(int'(idx)))
                    r.st = ST_FREE_IGNORED;
                else
                begin
                    // walk until a last page, a free page or the end
                    p = int'(idx);
                    while (p < n && page_busy(p))
                    begin
                        last        = pg_flags[p][1];
                        pg_flags[p] = 2'b00;
                        if (last)
                            break;
                        p++;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(120, 20);
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [ADDR_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_NUM_PAGES:      pg_num      = val[CNT_W-1:0];
            CFG_RESERVED_PAGES: pg_reserved = val[CNT_W-1:0];
            default:            pg_base     = val;
        endcase
    endtask

    // Offer one transaction; on acceptance record its expected result.
    task automatic send_request(input logic rt, input logic [CNT_W-1:0] cnt,
                                input logic [ADDR_W-1:0] fa, input bit known,
                                input alloc_result_t typed);
        alloc_result_t r;
        int            g;
        g = gap_len();
        if (g > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
        @(negedge clk);
        push         <= 1'b1;
        req_type     <= rt;
        page_count   <= cnt;
        free_address <= fa;
        do
            @(posedge clk);
        while (full);
        r = predict_request(rt, cnt, fa);
        pending_q.push_back(known ? typed : r);
        if (rt == 1'b0 && r.st == ST_DONE)
            live_blocks.push_back(r.ba);
        sent++;
    endtask

    task automatic end_offer();
        @(negedge clk);
        push <= 1'b0;
    endtask

    task automatic wait_idle();
        end_offer();
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_request(input setting_t s);
        alloc_result_t     none;
        int                r;
        int                n;
        int                k;
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] fa;
        logic [ADDR_W-1:0] pg;
        none = '{ST_DONE, '0};
        n    = live_count();
        r    = $urandom_range(99);
        cnt  = CNT_W'($urandom_range(8, 1));
        fa   = ADDR_W'({$urandom, $urandom});
        if (r < 50)
        begin
            if (s.big)
                cnt = CNT_W'($urandom_range(4, 1));
            else if ($urandom_range(9) == 0)
                cnt = CNT_W'($urandom_range(n + 2, 0));
            send_request(1'b0, cnt, fa, 1'b0, none);
        end
        else if (r < 85 && live_blocks.size() > 0)
        begin
            k  = $urandom_range(live_blocks.size() - 1);
            fa = live_blocks[k];
            if ($urandom_range(3) == 0)
                fa = fa + ADDR_W'($urandom_range(4095));
            live_blocks.delete(k);
            send_request(1'b1, cnt, fa, 1'b0, none);
        end
        else if (r < 92)
        begin
            pg = ADDR_W'($urandom_range(n + 1, 0));
            send_request(1'b1, cnt, pg_base + (pg << PAGE_SHIFT), 1'b0, none);
        end
        else if (s.big)
            send_request(1'b1, CNT_W'($urandom), fa, 1'b0, none);
        else
            send_request(1'($urandom_range(1)), CNT_W'($urandom), fa, 1'b0, none);
    endtask

    // result side: random pop gaps plus a long hold-off while the result count stands at 100
    initial
    begin
        alloc_result_t e;
        int            g;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (received == 100)
            begin
                pop <= 1'b0;
                repeat (400) @(negedge clk);
            end
            else
            begin
                g = gap_len();
                if (g > 0)
                begin
                    pop <= 1'b0;
                    repeat (g) @(negedge clk);
                end
            end
            pop <= 1'b1;
            @(posedge clk);
            if (!empty)
            begin
                received++;
                if (pending_q.size() == 0)
                begin
                    $error("unexpected result transaction: status %0d", status);
                    errors++;
                end
                else
                begin
                    e = pending_q.pop_front();
                    if (status !== e.st)
                    begin
                        $error("status: expected %0d, actual %0d", e.st, status);
                        errors++;
                    end
                    if (block_address !== e.ba)
                    begin
                        $error("block_address: expected %h, actual %h", e.ba, block_address);
                        errors++;
                    end
                end
            end
        end
    end

    // main sequence
    initial
    begin
        alloc_result_t typed;
        int            i;
        int            j;
        errors       = 0;
        sent         = 0;
        received     = 0;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_NUM_PAGES;
        cfg_data     = '0;
        push         = 1'b0;
        req_type     = 1'b0;
        page_count   = '0;
        free_address = '0;
        for (i = 0; i < MAX_PAGES; i++)
            pg_flags[i] = 2'b00;
        pg_num      = 16'd32768;
        pg_reserved = '0;
        pg_base     = RESET_BASE;

        // directed table under the reset settings
        dir_rows[0]  = '{0, 0,     0, 1, ST_BAD_COUNT,    0};
        dir_rows[1]  = '{0, 1,     0, 1, ST_DONE,         RESET_BASE};
        dir_rows[2]  = '{0, 2,     0, 1, ST_DONE,         56'h80001000};
        dir_rows[3]  = '{0, 65535, 0, 1, ST_BAD_COUNT,    0};
        dir_rows[4]  = '{0, 32769, 0, 1, ST_BAD_COUNT,    0};
        dir_rows[5]  = '{1, 0, 0,                  1, ST_FREE_IGNORED, 0};
        dir_rows[6]  = '{1, 0, 56'h7FFFFFFF,       1, ST_FREE_IGNORED, 0};
        dir_rows[7]  = '{1, 0, RESET_BASE,         1, ST_DONE,         0};
        dir_rows[8]  = '{1, 0, RESET_BASE,         1, ST_FREE_IGNORED, 0};
        dir_rows[9]  = '{1, 0, 56'h80001800,       1, ST_DONE,         0};
        dir_rows[10] = '{1, 0, 56'h88000000,       1, ST_FREE_IGNORED, 0};
        dir_rows[11] = '{1, 0, 56'hFFFFFFFFFFFFFF, 1, ST_FREE_IGNORED, 0};
        dir_rows[12] = '{0, 32768, 0, 1, ST_DONE,         RESET_BASE};
        dir_rows[13] = '{0, 1,     0, 1, ST_NO_ROOM,      0};
        dir_rows[14] = '{1, 0, 56'h80005000,       1, ST_DONE,         0};
        dir_rows[15] = '{0, 3,     0, 1, ST_DONE,         56'h80005000};
        dir_rows[16] = '{1, 0, RESET_BASE,         0, ST_DONE,         0};

        settings[0] = '{16'd64,    16'd4,     56'h0000_1000,     300, 0};
        settings[1] = '{16'd16,    16'd0,     56'h0,             150, 0};
        settings[2] = '{16'd65535, 16'd2,     56'hFF_FFFF_FFFF_E000, 20, 1};
        settings[3] = '{16'd40,    16'd40,    56'h1234_5678_9000, 60, 0};
        settings[4] = '{16'd1,     16'd0,     56'h00_0000_4000_0000, 100, 0};
        settings[5] = '{16'd100,   16'd0,     56'hFF_FFFF_FFFF_FFFF, 250, 0};
        settings[6] = '{16'd48,    16'd65535, 56'h0,             30, 0};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < 17; i++)
        begin
            typed = '{dir_rows[i].st, dir_rows[i].ba};
            send_request(dir_rows[i].rt, dir_rows[i].cnt, dir_rows[i].fa,
                         dir_rows[i].known, typed);
        end
        wait_idle();

        // random phases over several register settings
        for (i = 0; i < 7; i++)
        begin
            write_reg(CFG_NUM_PAGES, ADDR_W'(settings[i].n));
            write_reg(CFG_RESERVED_PAGES, ADDR_W'(settings[i].res));
            write_reg(CFG_MEMORY_BASE, settings[i].base);
            live_blocks.delete();
            for (j = 0; j < settings[i].items; j++)
                random_request(settings[i]);
            wait_idle();
        end

        $display("Sent %0d requests over 8 register settings; %0d results checked.",
                 sent, received);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
